FILE: sv/kcl_pkg.sv
// Shared types, codes and constants for the keypad code lock.
package kcl_pkg;

    // Code slots per entry; the card carries at most four code bytes.
    localparam int CODE_LENGTH = 4;
    localparam int CARD_BYTES  = 4;
    localparam int SLOT_IDX_W  = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]  BYTE_ABSENT = 8'hFF;
    localparam logic [15:0] TICK_MAX    = 16'hFFFF;

    localparam logic [15:0] TIMEOUT_RST   = 16'd75;
    localparam logic [2:0]  MAX_TRIES_RST = 3'd3;
    localparam logic [7:0]  KEY_UP_RST    = 8'd1;
    localparam logic [7:0]  KEY_DOWN_RST  = 8'd2;
    localparam logic [7:0]  KEY_LEFT_RST  = 8'd3;
    localparam logic [7:0]  KEY_RIGHT_RST = 8'd4;

    typedef enum logic [2:0] {
        KIND_CARD   = 3'd0,
        KIND_KEY    = 3'd1,
        KIND_ENTER  = 3'd2,
        KIND_TICK   = 3'd3,
        KIND_SET    = 3'd4,
        KIND_LOGOFF = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WAIT = 2'd1,
        MODE_SET  = 2'd2,
        MODE_IN   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        MSG_NONE        = 3'd0,
        MSG_CARD_OK     = 3'd1,
        MSG_LOGIN_OK    = 3'd2,
        MSG_LOGIN_WRONG = 3'd3,
        MSG_TIMEOUT     = 3'd4,
        MSG_NEW_CODE    = 3'd5
    } msg_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT   = 3'd0,
        CFG_MAX_TRIES = 3'd1,
        CFG_KEY_UP    = 3'd2,
        CFG_KEY_DOWN  = 3'd3,
        CFG_KEY_LEFT  = 3'd4,
        CFG_KEY_RIGHT = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  key_code;
        logic [7:0]  card_name_first;
        logic [31:0] card_code;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  message;
        logic        write_code_valid;
        logic [31:0] new_code;
        logic [2:0]  entered_count;
        logic [1:0]  session_mode;
    } out_item_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [2:0]  max_tries;
        logic [7:0]  key_up_code;
        logic [7:0]  key_down_code;
        logic [7:0]  key_left_code;
        logic [7:0]  key_right_code;
    } cfg_t;

    // Byte i of a card code word; slots past the card's bytes read as zero.
    function automatic logic [7:0] code_byte(input logic [31:0] word, input int i);
        logic [7:0] b;
        b = 8'd0;
        if (i < CARD_BYTES)
        begin
            b = word[8*i +: 8];
        end
        return b;
    endfunction

endpackage

FILE: sv/kcl_cfg.sv
// Configuration register file of the keypad code lock.
module kcl_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data,
    output kcl_pkg::cfg_t                  cfg
);
    import kcl_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks  <= TIMEOUT_RST;
            cfg_reg.max_tries      <= MAX_TRIES_RST;
            cfg_reg.key_up_code    <= KEY_UP_RST;
            cfg_reg.key_down_code  <= KEY_DOWN_RST;
            cfg_reg.key_left_code  <= KEY_LEFT_RST;
            cfg_reg.key_right_code <= KEY_RIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TIMEOUT:   cfg_reg.timeout_ticks  <= cfg_data[15:0];
                CFG_MAX_TRIES: cfg_reg.max_tries      <= cfg_data[2:0];
                CFG_KEY_UP:    cfg_reg.key_up_code    <= cfg_data[7:0];
                CFG_KEY_DOWN:  cfg_reg.key_down_code  <= cfg_data[7:0];
                CFG_KEY_LEFT:  cfg_reg.key_left_code  <= cfg_data[7:0];
                CFG_KEY_RIGHT: cfg_reg.key_right_code <= cfg_data[7:0];
                default:       ; // unmapped index, write dropped
            endcase
        end
    end

endmodule

FILE: sv/kcl_core.sv
// Session state machine and entry datapath of the keypad code lock.
module kcl_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  kcl_pkg::in_item_t   item,
    input  kcl_pkg::cfg_t       cfg,
    output kcl_pkg::out_item_t  result
);
    import kcl_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [31:0] stored_reg, stored_next;
    logic [2:0]  fill_reg, fill_next;
    logic [2:0]  tries_reg, tries_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [7:0]  slots_reg [CODE_LENGTH];

    logic        key_store;
    logic        card_ok;
    logic        code_match;
    logic        slots_full;
    logic        entry_open;
    logic        key_known;
    logic [2:0]  tries_inc;
    logic [15:0] ticks_inc;
    logic [31:0] entered_word;
    msg_t        msg;

    assign slots_full = (fill_reg >= 3'(CODE_LENGTH));
    assign entry_open = (mode_reg == MODE_WAIT) || (mode_reg == MODE_SET);
    assign key_known  = (item.key_code == cfg.key_up_code)
                     || (item.key_code == cfg.key_down_code)
                     || (item.key_code == cfg.key_left_code)
                     || (item.key_code == cfg.key_right_code);
    assign tries_inc  = 3'(tries_reg + 3'd1);
    assign ticks_inc  = (ticks_reg == TICK_MAX) ? ticks_reg : 16'(ticks_reg + 16'd1);

    always_comb
    begin
        card_ok    = (item.card_name_first != BYTE_ABSENT);
        code_match = 1'b1;
        entered_word = 32'd0;
        for (int i = 0; i < CODE_LENGTH; i++)
        begin
            if (i < CARD_BYTES)
            begin
                if (code_byte(item.card_code, i) == BYTE_ABSENT)
                begin
                    card_ok = 1'b0;
                end
                entered_word[8*i +: 8] = slots_reg[i];
            end
            if (slots_reg[i] != code_byte(stored_reg, i))
            begin
                code_match = 1'b0;
            end
        end
    end

    // Next state and result
    always_comb
    begin
        mode_next   = mode_reg;
        stored_next = stored_reg;
        fill_next   = fill_reg;
        tries_next  = tries_reg;
        ticks_next  = ticks_reg;
        key_store   = 1'b0;
        msg         = MSG_NONE;
        result.write_code_valid = 1'b0;
        result.new_code         = 32'd0;

        case (item.kind)
            KIND_CARD:
            begin
                if (mode_reg == MODE_IDLE && card_ok)
                begin
                    stored_next = item.card_code;
                    mode_next   = MODE_WAIT;
                    fill_next   = 3'd0;
                    tries_next  = 3'd0;
                    ticks_next  = 16'd0;
                    msg         = MSG_CARD_OK;
                end
            end
            KIND_KEY:
            begin
                if (entry_open && !slots_full && key_known)
                begin
                    key_store = 1'b1;
                    fill_next = 3'(fill_reg + 3'd1);
                end
            end
            KIND_ENTER:
            begin
                if (entry_open && slots_full)
                begin
                    fill_next = 3'd0;
                    if (mode_reg == MODE_WAIT)
                    begin
                        ticks_next = 16'd0;
                        if (code_match)
                        begin
                            mode_next  = MODE_IN;
                            tries_next = 3'd0;
                            msg        = MSG_LOGIN_OK;
                        end
                        else
                        begin
                            msg = MSG_LOGIN_WRONG;
                            if (tries_inc >= cfg.max_tries)
                            begin
                                tries_next = 3'd0;
                                mode_next  = MODE_IDLE;
                            end
                            else
                            begin
                                tries_next = tries_inc;
                            end
                        end
                    end
                    else
                    begin
                        result.write_code_valid = 1'b1;
                        result.new_code         = entered_word;
                        msg                     = MSG_NEW_CODE;
                        mode_next               = MODE_IDLE;
                    end
                end
            end
            KIND_TICK:
            begin
                if (mode_reg == MODE_WAIT)
                begin
                    if (ticks_inc >= cfg.timeout_ticks)
                    begin
                        mode_next  = MODE_IDLE;
                        ticks_next = 16'd0;
                        tries_next = 3'd0;
                        fill_next  = 3'd0;
                        msg        = MSG_TIMEOUT;
                    end
                    else
                    begin
                        ticks_next = ticks_inc;
                    end
                end
            end
            KIND_SET:
            begin
                mode_next  = MODE_SET;
                fill_next  = 3'd0;
                ticks_next = 16'd0;
            end
            KIND_LOGOFF:
            begin
                mode_next  = MODE_IDLE;
                fill_next  = 3'd0;
                tries_next = 3'd0;
                ticks_next = 16'd0;
            end
            default: ; // unused kinds leave state alone
        endcase

        result.message       = msg;
        result.entered_count = fill_next;
        result.session_mode  = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            stored_reg <= 32'd0;
            fill_reg   <= 3'd0;
            tries_reg  <= 3'd0;
            ticks_reg  <= 16'd0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            stored_reg <= stored_next;
            fill_reg   <= fill_next;
            tries_reg  <= tries_next;
            ticks_reg  <= ticks_next;
        end
    end

    // Slots are only read once all have been written
    always_ff @(posedge clk)
    begin
        if (step && key_store)
        begin
            slots_reg[fill_reg[SLOT_IDX_W-1:0]] <= item.key_code;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 3'(CODE_LENGTH))
        else $error("fill count past slot count");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE || mode_reg == MODE_IN) |-> fill_reg == 3'd0)
        else $error("slots filled outside entry");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(mode_reg) && $stable(fill_reg) && $stable(stored_reg))
        else $error("state moved without an item");

endmodule

FILE: sv/keypad_code_lock_core.sv
// Top level of the keypad code lock: item register, session core, result register.
//
// Usage:
//   item channel   (item_valid / item_ready / item): one event per item -
//                  card read, key press, enter, tick, set-code request, logoff.
//   result channel (result_valid / result_ready / result): exactly one result
//                  item per input item, in order: message, code to write back,
//                  slots filled and session mode after the event.
//   cfg channel    (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//                  writes, always ready; write only while the lock is idle.
// Result path: the item register loads at the accepting edge, and one pass
//   through the session logic then loads the result register once that is
//   free or being emptied.
// Throughput: one item per cycle while result_ready is high; the state update
//   in the session core sets this, each item seeing the state the previous left.
// Reset: session idle, stored code zero, counters cleared, registers at
//   their defaults; both pipeline registers empty.
// Stall: while result_ready is low the result register holds; the item
//   register still takes one more item, then item_ready drops.
module keypad_code_lock_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  kcl_pkg::in_item_t              item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output kcl_pkg::out_item_t             result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kcl_pkg::*;

    cfg_t      cfg;
    in_item_t  item_reg;
    logic      item_valid_reg;
    out_item_t core_result;
    out_item_t result_reg;
    logic      result_valid_reg;
    logic      advance;

    // item moves on when the result register is free or being emptied
    assign advance      = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !item_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    kcl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kcl_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // Item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
        else $error("stalled item lost");

    a_write_msg: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.write_code_valid |->
            result.message == MSG_NEW_CODE && result.session_mode == MODE_IDLE)
        else $error("code write without acknowledge");

    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.write_code_valid |-> result.new_code == 32'd0)
        else $error("new code driven without write");

endmodule
